FILE: rtl/sfu_pkg.sv
// Shared types, sizes and saturation helpers for the SGD factor update engine.
// Used by sfu_mul_unit and sgd_factor_update_engine_top; no dependencies.
package sfu_pkg;

   localparam int NUM_USERS    = 256;
   localparam int NUM_ITEMS    = 256;
   localparam int NUM_FEATURES = 32;
   localparam int VALUE_WIDTH  = 24;

   localparam int USER_W = $clog2(NUM_USERS);
   localparam int ITEM_W = $clog2(NUM_ITEMS);
   localparam int FEAT_W = $clog2(NUM_FEATURES);
   localparam int PADDR_W = USER_W + FEAT_W;
   localparam int QADDR_W = ITEM_W + FEAT_W;

   // shared multiplier operand and result widths: the wide side carries the
   // error and gradients, the narrow side a stored value or a Q0.16 rate
   localparam int OPA_W  = 44;
   localparam int OPB_W  = VALUE_WIDTH + 1;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int RND_W  = 48;
   localparam int ACC_W  = 40;
   localparam int SUM_W  = 49;

   typedef enum logic [2:0] {
      CMD_WR_USER = 3'd0,
      CMD_WR_ITEM = 3'd1,
      CMD_WR_BIAS = 3'd2,
      CMD_RD_USER = 3'd3,
      CMD_RD_ITEM = 3'd4,
      CMD_RD_BIAS = 3'd5,
      CMD_TRAIN   = 3'd6,
      CMD_PREDICT = 3'd7
   } cmd_type;

   typedef enum logic {
      CSR_LEARN_RATE = 1'b0,
      CSR_REG_WEIGHT = 1'b1
   } csr_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISP, S_RDW, S_BIAS,
      S_E_RD, S_E_MUL, S_E_RND, S_E_ACC, S_ERR,
      S_U_RD, S_U_MG, S_U_R1, S_U_MRP, S_U_R2, S_U_MLB, S_U_R3, S_U_MLP,
      S_U_R4, S_U_PUPD, S_U_MH, S_U_R5, S_U_MRQ, S_U_R6, S_U_DQ, S_U_MLQ,
      S_U_R7, S_U_QWR, S_BWR, S_DONE
   } state_type;

   localparam logic signed [SUM_W-1:0] VAL_MAX = SUM_W'(2**(VALUE_WIDTH-1) - 1);
   localparam logic signed [SUM_W-1:0] VAL_MIN = -SUM_W'(2**(VALUE_WIDTH-1));
   localparam logic signed [ACC_W-1:0] ERR_MAX = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] ERR_MIN = -ACC_W'(64'sd2147483648);

   // clip a wide sum to a stored value
   function automatic logic signed [VALUE_WIDTH-1:0] clip_val(
         input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      r = (v > VAL_MAX) ? VAL_MAX : ((v < VAL_MIN) ? VAL_MIN : v);
      return r[VALUE_WIDTH-1:0];
   endfunction

   function automatic logic ovf_val(input logic signed [SUM_W-1:0] v);
      return (v > VAL_MAX) || (v < VAL_MIN);
   endfunction

   // clip the error accumulator to 32 bits
   function automatic logic signed [31:0] clip_err(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = (v > ERR_MAX) ? ERR_MAX : ((v < ERR_MIN) ? ERR_MIN : v);
      return r[31:0];
   endfunction

   function automatic logic ovf_err(input logic signed [ACC_W-1:0] v);
      return (v > ERR_MAX) || (v < ERR_MIN);
   endfunction

endpackage

FILE: rtl/sgd_factor_update_engine_top.sv
// Top level of the SGD factor update engine: factor and bias memories,
// command sequencer and configuration registers. Depends on sfu_pkg, sfu_mul_unit.
//
// Usage: each req_ item is one command (write, read, train or predict) and
// gives exactly one rsp_ item. Configuration is written on csr_we with csr_index
// 0 (learn rate) or 1 (regularization weight); the user must write it only
// while the block is idle, which the block itself does not enforce. The block
// takes one item at a time; req_tready is high only when idle.
// Each feature of the error pass and of the update pass is paced by the
// single shared multiplier (two-stage product and rounding) that every
// product of the update goes through in order, plus one memory read.
// The result waits in an output register; a new item is accepted while it
// waits, and the sequencer holds at its last step if the register is still full.
// Reset sets the configuration defaults and empties the output register;
// memory contents are undefined until written.
module sgd_factor_update_engine_top
   import sfu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // cmd[2:0], user[10:3], item[18:11], feature[23:19], value[47:24], rating[55:48]
   input  logic [55:0]  req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // read_value[23:0], error[55:24]
   output logic [55:0]  rsp_tdata,
   // saturated[0]
   output logic         rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);

   localparam logic [FEAT_W-1:0] K_LAST = FEAT_W'(NUM_FEATURES - 1);

   state_type state_ff, state_in;

   // latched command
   cmd_type                        cmd_ff, cmd_in;
   logic [USER_W-1:0]              user_ff, user_in;
   logic [ITEM_W-1:0]              item_ff, item_in;
   logic [FEAT_W-1:0]              feat_ff, feat_in;
   logic signed [VALUE_WIDTH-1:0]  value_ff, value_in;
   logic [7:0]                     rating_ff, rating_in;

   // working registers
   logic [FEAT_W-1:0]              k_ff, k_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [31:0]             err_ff, err_in;
   logic                           sat_ff, sat_in;
   logic signed [23:0]             rdv_ff, rdv_in;
   logic signed [VALUE_WIDTH-1:0]  b_ff, b_in, p_ff, p_in, q_ff, q_in;
   logic signed [OPA_W-1:0]        g_ff, g_in, diff_ff, diff_in;

   // output register
   logic                           out_v_ff, out_v_in;
   logic [55:0]                    out_data_ff, out_data_in;
   logic                           out_sat_ff, out_sat_in;

   // configuration
   logic [15:0]                    lr_ff, rw_ff;

   // memories
   logic signed [VALUE_WIDTH-1:0]  pmem [NUM_USERS*NUM_FEATURES];
   logic signed [VALUE_WIDTH-1:0]  qmem [NUM_ITEMS*NUM_FEATURES];
   logic signed [VALUE_WIDTH-1:0]  bmem [NUM_USERS];
   logic [PADDR_W-1:0]             p_addr;
   logic [QADDR_W-1:0]             q_addr;
   logic [USER_W-1:0]              b_addr;
   logic                           p_we, q_we, b_we;
   logic signed [VALUE_WIDTH-1:0]  p_wdata, q_wdata, b_wdata;
   logic signed [VALUE_WIDTH-1:0]  p_rd_ff, q_rd_ff, b_rd_ff;

   // multiplier
   logic signed [OPA_W-1:0]        op_a;
   logic signed [OPB_W-1:0]        op_b;
   logic signed [RND_W-1:0]        rnd;

   // helper sums
   logic signed [VALUE_WIDTH:0]    prd_plus_b, p_plus_b;
   logic signed [SUM_W-1:0]        b_sum, p_sum, q_sum;

   sfu_mul_unit u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .rnd   (rnd)
   );

   assign prd_plus_b = (VALUE_WIDTH+1)'(p_rd_ff) + (VALUE_WIDTH+1)'(b_ff);
   assign p_plus_b   = (VALUE_WIDTH+1)'(p_ff) + (VALUE_WIDTH+1)'(b_ff);
   assign b_sum      = SUM_W'(b_ff) + SUM_W'(rnd);
   assign p_sum      = SUM_W'(p_ff) + SUM_W'(rnd);
   assign q_sum      = SUM_W'(q_ff) + SUM_W'(rnd);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_sat_ff;

   // sequencer: next state, datapath controls
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      user_in     = user_ff;
      item_in     = item_ff;
      feat_in     = feat_ff;
      value_in    = value_ff;
      rating_in   = rating_ff;
      k_in        = k_ff;
      acc_in      = acc_ff;
      err_in      = err_ff;
      sat_in      = sat_ff;
      rdv_in      = rdv_ff;
      b_in        = b_ff;
      p_in        = p_ff;
      q_in        = q_ff;
      g_in        = g_ff;
      diff_in     = diff_ff;
      out_v_in    = out_v_ff && !rsp_tready;
      out_data_in = out_data_ff;
      out_sat_in  = out_sat_ff;
      p_addr      = {user_ff, k_ff};
      q_addr      = {item_ff, k_ff};
      b_addr      = user_ff;
      p_we        = 1'b0;
      q_we        = 1'b0;
      b_we        = 1'b0;
      p_wdata     = value_ff;
      q_wdata     = value_ff;
      b_wdata     = value_ff;
      op_a        = '0;
      op_b        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = cmd_type'(req_tdata[2:0]);
               user_in   = req_tdata[3 +: USER_W];
               item_in   = req_tdata[11 +: ITEM_W];
               feat_in   = req_tdata[19 +: FEAT_W];
               value_in  = req_tdata[47:24];
               rating_in = req_tdata[55:48];
               err_in    = '0;
               rdv_in    = '0;
               sat_in    = 1'b0;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            p_addr = {user_ff, feat_ff};
            q_addr = {item_ff, feat_ff};
            case (cmd_ff)
               CMD_WR_USER: begin
                  p_we     = 1'b1;
                  state_in = S_DONE;
               end
               CMD_WR_ITEM: begin
                  q_we     = 1'b1;
                  state_in = S_DONE;
               end
               CMD_WR_BIAS: begin
                  b_we     = 1'b1;
                  state_in = S_DONE;
               end
               CMD_RD_USER, CMD_RD_ITEM, CMD_RD_BIAS: begin
                  state_in = S_RDW;
               end
               default: begin
                  acc_in   = ACC_W'({rating_ff, 16'd0});
                  k_in     = '0;
                  state_in = S_BIAS;
               end
            endcase
         end
         S_RDW: begin
            case (cmd_ff)
               CMD_RD_USER: rdv_in = p_rd_ff;
               CMD_RD_ITEM: rdv_in = q_rd_ff;
               default:     rdv_in = b_rd_ff;
            endcase
            state_in = S_DONE;
         end
         S_BIAS: begin
            b_in     = b_rd_ff;
            state_in = S_E_RD;
         end
         // error pass: acc -= (p + b) * q, one feature at a time
         S_E_RD:  state_in = S_E_MUL;
         S_E_MUL: begin
            op_a     = OPA_W'(prd_plus_b);
            op_b     = OPB_W'(q_rd_ff);
            state_in = S_E_RND;
         end
         S_E_RND: state_in = S_E_ACC;
         S_E_ACC: begin
            acc_in = acc_ff - rnd[ACC_W-1:0];
            if (k_ff == K_LAST) begin
               state_in = S_ERR;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_E_RD;
            end
         end
         S_ERR: begin
            err_in = clip_err(acc_ff);
            sat_in = sat_ff | ovf_err(acc_ff);
            if (cmd_ff == CMD_TRAIN && rating_ff != 8'd0) begin
               k_in     = '0;
               state_in = S_U_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         // update pass: bias, user factor, item factor per feature
         S_U_RD: state_in = S_U_MG;
         S_U_MG: begin
            p_in     = p_rd_ff;
            q_in     = q_rd_ff;
            op_a     = OPA_W'(err_ff);
            op_b     = OPB_W'(q_rd_ff);
            state_in = S_U_R1;
         end
         S_U_R1: state_in = S_U_MRP;
         S_U_MRP: begin
            g_in     = {rnd[OPA_W-2:0], 1'b0};
            op_a     = OPA_W'(p_ff);
            op_b     = OPB_W'({1'b0, rw_ff});
            state_in = S_U_R2;
         end
         S_U_R2: state_in = S_U_MLB;
         S_U_MLB: begin
            diff_in  = g_ff - OPA_W'(rnd);
            op_a     = g_ff;
            op_b     = OPB_W'({1'b0, lr_ff});
            state_in = S_U_R3;
         end
         S_U_R3: state_in = S_U_MLP;
         S_U_MLP: begin
            b_in     = clip_val(b_sum);
            sat_in   = sat_ff | ovf_val(b_sum);
            op_a     = diff_ff;
            op_b     = OPB_W'({1'b0, lr_ff});
            state_in = S_U_R4;
         end
         S_U_R4: state_in = S_U_PUPD;
         S_U_PUPD: begin
            p_in     = clip_val(p_sum);
            sat_in   = sat_ff | ovf_val(p_sum);
            state_in = S_U_MH;
         end
         S_U_MH: begin
            op_a     = OPA_W'(err_ff);
            op_b     = OPB_W'(p_plus_b);
            state_in = S_U_R5;
         end
         S_U_R5: state_in = S_U_MRQ;
         S_U_MRQ: begin
            g_in     = {rnd[OPA_W-2:0], 1'b0};
            op_a     = OPA_W'(q_ff);
            op_b     = OPB_W'({1'b0, rw_ff});
            state_in = S_U_R6;
         end
         S_U_R6: state_in = S_U_DQ;
         S_U_DQ: begin
            diff_in  = g_ff - OPA_W'(rnd);
            state_in = S_U_MLQ;
         end
         S_U_MLQ: begin
            op_a     = diff_ff;
            op_b     = OPB_W'({1'b0, lr_ff});
            state_in = S_U_R7;
         end
         S_U_R7: state_in = S_U_QWR;
         S_U_QWR: begin
            p_we    = 1'b1;
            p_wdata = p_ff;
            q_we    = 1'b1;
            q_wdata = clip_val(q_sum);
            sat_in  = sat_ff | ovf_val(q_sum);
            if (k_ff == K_LAST) begin
               state_in = S_BWR;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_U_RD;
            end
         end
         S_BWR: begin
            b_we     = 1'b1;
            b_wdata  = b_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!out_v_ff || rsp_tready) begin
               out_v_in    = 1'b1;
               out_data_in = {err_ff, rdv_ff};
               out_sat_in  = sat_ff;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      user_ff     <= user_in;
      item_ff     <= item_in;
      feat_ff     <= feat_in;
      value_ff    <= value_in;
      rating_ff   <= rating_in;
      k_ff        <= k_in;
      acc_ff      <= acc_in;
      err_ff      <= err_in;
      sat_ff      <= sat_in;
      rdv_ff      <= rdv_in;
      b_ff        <= b_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      g_ff        <= g_in;
      diff_ff     <= diff_in;
      out_data_ff <= out_data_in;
      out_sat_ff  <= out_sat_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= 16'd131;
         rw_ff <= 16'd6554;
      end else if (csr_we) begin
         case (csr_type'(csr_index))
            CSR_LEARN_RATE: lr_ff <= csr_wdata;
            CSR_REG_WEIGHT: rw_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // factor and bias memories, registered read
   always_ff @(posedge clock) begin
      if (p_we) pmem[p_addr] <= p_wdata;
      p_rd_ff <= pmem[p_addr];
   end

   always_ff @(posedge clock) begin
      if (q_we) qmem[q_addr] <= q_wdata;
      q_rd_ff <= qmem[q_addr];
   end

   always_ff @(posedge clock) begin
      if (b_we) bmem[b_addr] <= b_wdata;
      b_rd_ff <= bmem[b_addr];
   end

   // an accepted item always leaves idle on the next cycle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_DISP))
      else $error("accepted item did not start the sequencer");

   // user factors change only by a write command or a rated train command
   a_user_write_legal: assert property (@(posedge clock) disable iff (reset)
      p_we |-> (cmd_ff == CMD_WR_USER || (cmd_ff == CMD_TRAIN && rating_ff != 8'd0)))
      else $error("user factor written by wrong command");

   // a result is loaded only when the output register is free or draining
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_tready) |=> (out_v_ff && $stable(out_data_ff)))
      else $error("pending result overwritten");

endmodule

FILE: rtl/sfu_mul_unit.sv
// Shared signed multiplier with Q.16 rounding, halves away from zero.
// Two register stages: product, then rounded result. Depends on sfu_pkg.
module sfu_mul_unit
   import sfu_pkg::*;
(
   input  logic                     clock,
   input  logic signed [OPA_W-1:0]  op_a,
   input  logic signed [OPB_W-1:0]  op_b,
   output logic signed [RND_W-1:0]  rnd
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [RND_W-1:0]  rnd_ff;
   logic signed [RND_W-1:0]  rnd_in;
   logic [PROD_W-1:0]        mag;
   logic [PROD_W-1:0]        mag_rnd;
   logic [RND_W-1:0]         m;

   // multiply
   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   // round the magnitude, then restore the sign
   always_comb begin
      mag     = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      mag_rnd = mag + PROD_W'(32768);
      m       = mag_rnd[16 +: RND_W];
      rnd_in  = prod_ff[PROD_W-1] ? -$signed(m) : $signed(m);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rnd_ff  <= rnd_in;
   end

   assign rnd = rnd_ff;

endmodule
